// File: rtl/core/fud_pkg.sv
package fud_pkg;

    // Delimiter and substitution characters.
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Width of the packed result data bus and of the sideband.
    localparam int unsigned TDATA_W = 16;
    localparam int unsigned TUSER_W = 2;

    // Progress through a percent escape.
    typedef enum logic [1:0] {
        ESC_PLAIN = 2'd0,
        ESC_HIGH  = 2'd1,
        ESC_LOW   = 2'd2
    } escape_step_t;

    // One raw input beat.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       is_last;
    } fud_item_t;

    // One decoded result beat.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] decoded_byte;
        logic       in_value;
        logic       name_done;
        logic       pair_done;
        logic       name_dropped;
        logic       stream_end;
    } fud_result_t;

    // Hex digit of either case to its nibble; anything else counts as zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

// File: rtl/core/fud_in_reg.sv
module fud_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] raw_byte
    input  logic                s_tlast,
    input  logic                advance,
    output logic                item_valid,
    output fud_pkg::fud_item_t  item
);
    import fud_pkg::*;

    logic       valid_reg;
    fud_item_t  item_reg;

    // Take a new beat whenever the held one is empty or moving on.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag of the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.raw_byte <= s_tdata;
            item_reg.is_last  <= s_tlast;
        end
    end

endmodule

// File: rtl/core/fud_decode.sv
module fud_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  fud_pkg::fud_item_t    item,
    output fud_pkg::fud_result_t  result
);
    import fud_pkg::*;

    logic          phase_reg;
    logic          phase_next;
    escape_step_t  esc_reg;
    escape_step_t  esc_next;
    logic [3:0]    nib_reg;
    logic [3:0]    nib_next;
    logic [3:0]    nib_in;

    assign nib_in = hex_nibble(item.raw_byte);

    // Decode one byte against the current field state.
    always_comb begin
        phase_next          = phase_reg;
        esc_next            = esc_reg;
        nib_next            = nib_reg;
        result.byte_valid   = 1'b0;
        result.decoded_byte = 8'h00;
        result.in_value     = phase_reg;
        result.name_done    = 1'b0;
        result.pair_done    = 1'b0;
        result.name_dropped = 1'b0;
        result.stream_end   = item.is_last;

        if (!phase_reg && item.raw_byte == CH_EQUALS) begin
            // Equals sign closes the name; a last byte also closes an empty value.
            result.name_done = 1'b1;
            result.pair_done = item.is_last;
            phase_next       = 1'b1;
            esc_next         = ESC_PLAIN;
            nib_next         = 4'h0;
        end else if (phase_reg && item.raw_byte == CH_AMP) begin
            // Ampersand closes the value and any unfinished escape is lost.
            result.pair_done = 1'b1;
            phase_next       = 1'b0;
            esc_next         = ESC_PLAIN;
            nib_next         = 4'h0;
        end else begin
            unique case (esc_reg)
                ESC_HIGH: begin
                    nib_next = nib_in;
                    esc_next = ESC_LOW;
                end
                ESC_LOW: begin
                    result.byte_valid   = 1'b1;
                    result.decoded_byte = {nib_reg, nib_in};
                    esc_next            = ESC_PLAIN;
                end
                default: begin
                    esc_next = ESC_PLAIN;
                    if (item.raw_byte == CH_PERCENT) begin
                        esc_next = ESC_HIGH;
                    end else if (item.raw_byte == CH_PLUS) begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = CH_SPACE;
                    end else begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = item.raw_byte;
                    end
                end
            endcase
            if (item.is_last) begin
                result.pair_done    = phase_reg;
                result.name_dropped = !phase_reg;
            end
        end

        // The end of a body returns everything to the start of a name.
        if (item.is_last) begin
            phase_next = 1'b0;
            esc_next   = ESC_PLAIN;
            nib_next   = 4'h0;
        end
    end

    // Field state advances once per decoded beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            esc_reg   <= ESC_PLAIN;
            nib_reg   <= 4'h0;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            nib_reg   <= nib_next;
        end
    end

    // After the last byte of a body the decoder is back at the start of a name.
    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.is_last) |=> (!phase_reg && esc_reg == ESC_PLAIN && nib_reg == 4'h0))
        else $error("decoder state not cleared after last byte");

    // A closed name only comes from the name phase.
    a_name_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.name_done) |-> !result.in_value)
        else $error("name closed while in value phase");

    // A dropped name needs the end of the body in the name phase.
    a_drop_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.name_dropped) |-> (result.stream_end && !result.in_value))
        else $error("name dropped outside end of body");

    // Unless a delimiter or the end of the body comes, the high digit of an escape moves it on to its low digit.
    a_escape_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && esc_reg == ESC_HIGH && !item.is_last
         && !(phase_reg && item.raw_byte == CH_AMP)
         && !(!phase_reg && item.raw_byte == CH_EQUALS)) |=> (esc_reg == ESC_LOW))
        else $error("escape did not advance to its low digit");

endmodule

// File: rtl/core/fud_out_reg.sv
module fud_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  fud_pkg::fud_result_t  result,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [fud_pkg::TDATA_W-1:0] m_tdata,
    output logic [fud_pkg::TUSER_W-1:0] m_tuser,
    output logic                  m_tlast
);
    import fud_pkg::*;

    logic         valid_reg;
    fud_result_t  res_reg;

    // Room for a new result when empty or when the held beat leaves now.
    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b00000, res_reg.name_dropped, res_reg.pair_done,
                       res_reg.name_done, res_reg.decoded_byte};
    assign m_tuser  = {res_reg.in_value, res_reg.byte_valid};
    assign m_tlast  = res_reg.stream_end;

    // Valid flag of the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // Payload of the result register.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

endmodule

// File: rtl/core/form_urlencoded_pair_decoder_top.sv
// Path: a beat accepted into the input register moves into the result register
// once that register has room, and is offered on the output from there
// (input register, then result register).
// Throughput: one byte per cycle while the receiver keeps m_tready high.
// Reset: synchronous, active low; clears both valid flags and returns the
// decoder to the start of a name with no escape pending.
module form_urlencoded_pair_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] decoded_byte, [8] name_done,
                                   // [9] pair_done, [10] name_dropped, [15:11] zero
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] in_value
    output logic        m_tlast    // stream_end
);
    import fud_pkg::*;

    logic         item_valid;
    fud_item_t    item;
    fud_result_t  result;
    logic         can_load;
    logic         advance;

    // A beat moves from input to result register when both allow it.
    assign advance = item_valid && can_load;

    fud_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fud_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .result  (result)
    );

    fud_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import fud_pkg::*;

    // One stimulus row: the raw beat, and optionally a result typed in by hand.
    typedef struct packed {
        logic [7:0]  raw;
        logic        last;
        logic        typed;
        fud_result_t want;
    } form_beat_t;

    localparam int unsigned DIR_ROWS   = 24;
    localparam int unsigned RAND_BYTES = 1500;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    form_beat_t  body_bytes[$];
    form_beat_t  offered_bytes[$];
    fud_result_t due_results[$];
    int unsigned err_count = 0;

    // Decoder state as the testbench sees it.
    logic         value_side = 1'b0;
    escape_step_t esc_step   = ESC_PLAIN;
    logic [3:0]   hi_nib     = 4'h0;

    // Receiver stall pattern.
    int unsigned  rx_mode = 0;
    int unsigned  rx_left = 0;
    logic [7:0]   rx_tick = 8'h00;

    // Directed rows: extremes, both substitutions, both hex cases, non-hex digits,
    // delimiters in the other phase and inside escapes, and the three ways a body ends.
    form_beat_t dir_tab [DIR_ROWS] = '{
        '{8'h00,      1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'hFF,      1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CH_AMP,     1'b0, 1'b1, '{1'b1, 8'h26, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CH_PLUS,    1'b0, 1'b1, '{1'b1, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CH_PERCENT, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{"4",        1'b0, 1'b0, '0},
        '{"1",        1'b0, 1'b1, '{1'b1, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CH_PERCENT, 1'b0, 1'b0, '0},
        '{"a",        1'b0, 1'b0, '0},
        '{"F",        1'b0, 1'b0, '0},
        '{CH_EQUALS,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{CH_EQUALS,  1'b0, 1'b1, '{1'b1, 8'h3D, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CH_PERCENT, 1'b0, 1'b0, '0},
        '{"g",        1'b0, 1'b0, '0},
        '{"z",        1'b0, 1'b0, '0},
        '{CH_PERCENT, 1'b0, 1'b0, '0},
        '{CH_AMP,     1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{"k",        1'b0, 1'b0, '0},
        '{CH_PERCENT, 1'b0, 1'b0, '0},
        '{CH_EQUALS,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{CH_PERCENT, 1'b0, 1'b0, '0},
        '{"7",        1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{CH_EQUALS,  1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{"x",        1'b1, 1'b1, '{1'b1, 8'h78, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}}
    };

    form_urlencoded_pair_decoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Hex digit to nibble; letters A-F and a-f share their low four bits plus nine.
    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        if (ch inside {[8'h30:8'h39]}) begin
            return ch[3:0];
        end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return ch[3:0] + 4'd9;
        end
        return 4'h0;
    endfunction

    // Decodes one raw byte against the tracked state and returns its result.
    function automatic fud_result_t decode_form_byte(input logic [7:0] ch, input logic fin);
        fud_result_t r;
        r = '0;
        r.in_value   = value_side;
        r.stream_end = fin;
        if (!value_side && ch == CH_EQUALS) begin
            r.name_done = 1'b1;
            r.pair_done = fin;
            value_side  = 1'b1;
            esc_step    = ESC_PLAIN;
            hi_nib      = 4'h0;
        end else if (value_side && ch == CH_AMP) begin
            r.pair_done = 1'b1;
            value_side  = 1'b0;
            esc_step    = ESC_PLAIN;
            hi_nib      = 4'h0;
        end else begin
            case (esc_step)
                ESC_HIGH: begin
                    hi_nib   = nibble_of(ch);
                    esc_step = ESC_LOW;
                end
                ESC_LOW: begin
                    r.byte_valid   = 1'b1;
                    r.decoded_byte = {hi_nib, nibble_of(ch)};
                    esc_step       = ESC_PLAIN;
                end
                default: begin
                    esc_step = ESC_PLAIN;
                    if (ch == CH_PERCENT) begin
                        esc_step = ESC_HIGH;
                    end else if (ch == CH_PLUS) begin
                        r.byte_valid   = 1'b1;
                        r.decoded_byte = CH_SPACE;
                    end else begin
                        r.byte_valid   = 1'b1;
                        r.decoded_byte = ch;
                    end
                end
            endcase
            if (fin) begin
                if (r.in_value) begin
                    r.pair_done = 1'b1;
                end else begin
                    r.name_dropped = 1'b1;
                end
            end
        end
        // The last byte of a body returns the decoder to the start of a name.
        if (fin) begin
            value_side = 1'b0;
            esc_step   = ESC_PLAIN;
            hi_nib     = 4'h0;
        end
        return r;
    endfunction

    task automatic push_char(input logic [7:0] ch);
        form_beat_t b;
        b       = '0;
        b.raw   = ch;
        body_bytes.push_back(b);
    endtask

    // Any byte but the delimiter that would close the current field.
    function automatic logic [7:0] field_byte(input logic value_part, input logic [7:0] ch);
        if (ch == (value_part ? CH_AMP : CH_EQUALS)) begin
            return "x";
        end
        return ch;
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return 8'h30 + r[7:0];
        end else if (r < 16) begin
            return 8'h41 + r[7:0] - 8'd10;
        end
        return 8'h61 + r[7:0] - 8'd16;
    endfunction

    // One field of n elements: plain text, spaces, good and broken escapes, raw bytes.
    task automatic add_field(input logic value_part, input int unsigned n);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                push_char(field_byte(value_part, 8'($urandom_range(8'h21, 8'h7E))));
            end else if (r < 55) begin
                push_char(CH_PLUS);
            end else if (r < 80) begin
                push_char(CH_PERCENT);
                push_char(hex_char());
                push_char(hex_char());
            end else if (r < 88) begin
                push_char(CH_PERCENT);
                push_char(field_byte(value_part, 8'($urandom_range(0, 255))));
                if ($urandom_range(0, 1) == 0) begin
                    push_char(field_byte(value_part, 8'($urandom_range(0, 255))));
                end
            end else begin
                push_char(field_byte(value_part, 8'($urandom_range(0, 255))));
            end
        end
    endtask

    // One body: mostly well-formed pairs, sometimes raw noise.
    task automatic add_body();
        form_beat_t  b;
        int unsigned pairs;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                push_char(8'($urandom_range(0, 255)));
            end
        end else begin
            pairs = $urandom_range(1, 4);
            for (int unsigned p = 0; p < pairs; p++) begin
                add_field(1'b0, $urandom_range(0, 6));
                if (p == pairs - 1 && $urandom_range(0, 7) == 0) begin
                    // Body ends inside a name.
                    push_char("n");
                end else begin
                    push_char(CH_EQUALS);
                    add_field(1'b1, $urandom_range(0, 8));
                    if (p < pairs - 1) begin
                        push_char(CH_AMP);
                    end
                end
            end
        end
        b      = body_bytes.pop_back();
        b.last = 1'b1;
        body_bytes.push_back(b);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    // Compares one result beat with the oldest expectation.
    task automatic check_result();
        fud_result_t w;
        if (due_results.size() == 0) begin
            err_count++;
            if (err_count <= 10) begin
                $display("unexpected result beat: tdata %0h tuser %0h", m_tdata, m_tuser);
            end
        end else begin
            w = due_results.pop_front();
            if (m_tuser[0] !== w.byte_valid) begin
                note_mismatch("byte_valid", 32'(w.byte_valid), 32'(m_tuser[0]));
            end
            if (m_tdata[7:0] !== w.decoded_byte) begin
                note_mismatch("decoded_byte", 32'(w.decoded_byte), 32'(m_tdata[7:0]));
            end
            if (m_tuser[1] !== w.in_value) begin
                note_mismatch("in_value", 32'(w.in_value), 32'(m_tuser[1]));
            end
            if (m_tdata[8] !== w.name_done) begin
                note_mismatch("name_done", 32'(w.name_done), 32'(m_tdata[8]));
            end
            if (m_tdata[9] !== w.pair_done) begin
                note_mismatch("pair_done", 32'(w.pair_done), 32'(m_tdata[9]));
            end
            if (m_tdata[10] !== w.name_dropped) begin
                note_mismatch("name_dropped", 32'(w.name_dropped), 32'(m_tdata[10]));
            end
            if (m_tlast !== w.stream_end) begin
                note_mismatch("stream_end", 32'(w.stream_end), 32'(m_tlast));
            end
            if (m_tdata[15:11] !== 5'd0) begin
                note_mismatch("tdata padding", 32'd0, 32'(m_tdata[15:11]));
            end
        end
    endtask

    // Monitor: checks result beats, then predicts each accepted input beat.
    always @(posedge aclk) begin
        form_beat_t  b;
        fud_result_t r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                b = offered_bytes.pop_front();
                r = decode_form_byte(b.raw, b.last);
                due_results.push_back(b.typed ? b.want : r);
            end
        end
    end

    // Receiver: switches between free flow, random stalls, a fixed duty pattern
    // and heavy back-pressure.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= rx_tick[2];
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Sender: builds the byte stream, drives it in bursts, then drains.
    initial begin
        form_beat_t  b;
        int unsigned burst_left;
        int unsigned drain_cycles;
        int unsigned mid_point;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        burst_left = 0;
        drain_cycles = 0;
        foreach (dir_tab[i]) begin
            body_bytes.push_back(dir_tab[i]);
        end
        while (body_bytes.size() < DIR_ROWS + RAND_BYTES) begin
            add_body();
        end
        mid_point = DIR_ROWS + RAND_BYTES / 2;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int unsigned i = 0; i < body_bytes.size(); i++) begin
            // Hold off until every result is back, after the directed rows and midway.
            if (i == DIR_ROWS || i == mid_point) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (offered_bytes.size() != 0 || due_results.size() != 0) begin
                    @(posedge aclk);
                end
            end
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? 25 : $urandom_range(1, 6)) begin
                    @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            end
            b = body_bytes[i];
            offered_bytes.push_back(b);
            s_tvalid <= 1'b1;
            s_tdata  <= b.raw;
            s_tlast  <= b.last;
            do begin
                @(posedge aclk);
            end while (!s_tready);
            burst_left--;
        end
        s_tvalid <= 1'b0;

        // Wait for outstanding results before the final check.
        while ((offered_bytes.size() != 0 || due_results.size() != 0)
               && drain_cycles < 50000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);
        if (due_results.size() != 0) begin
            err_count += due_results.size();
            $display("%0d expected results never arrived", due_results.size());
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
